// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker module pfc_checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFC_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PFC_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/pfc_pkg.sv -----
// constants and types for the plate format checker
// no dependencies
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int CH_W   = 8;
  localparam int CP_W   = 16;
  localparam int ACC_W  = 21;
  localparam int RUN_W  = 3;
  localparam int CONT_W = 2;

  localparam logic [ACC_W-1:0] SYL_LOW  = 21'h00AC00;
  localparam logic [ACC_W-1:0] SYL_HIGH = 21'h00D7A3;

  localparam logic [RUN_W-1:0] PREFIX_MAX = 3'd3;
  localparam logic [RUN_W-1:0] PREFIX_MIN = 3'd2;
  localparam logic [RUN_W-1:0] SUFFIX_LEN = 3'd4;

  typedef struct packed {
    logic            plate_ok;
    logic [CP_W-1:0] letter_codepoint;
  } result_t;

endpackage

// ----- hw/rtl/plate_format_checker.sv -----
// plate format checker: per-string plate pattern check on a byte stream
// depends on pfc_pkg
//
//  port group  dir  handshake          payload
//  in_         in   in_valid/in_stall  in_ch
//  out_        out  out_valid/out_stall out_plate_ok, out_letter_codepoint
//
// one word per cycle while in_stall is low; each word updates the pattern state in the accept cycle
// a zero word's result goes to the output register, or to the skid buffer while the output is stalled
// a one-entry skid buffer lets input continue while a result waits
// in_stall is registered and high only while the skid buffer is full
// reset (rst_n low, synchronous) returns to expecting the first prefix digit
`timescale 1ns / 1ps

module plate_format_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [pfc_pkg::CH_W-1:0] in_ch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_plate_ok,
  output logic [pfc_pkg::CP_W-1:0] out_letter_codepoint
);

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_CONT   = 2'd1;
  localparam logic [1:0] PH_SUFFIX = 2'd2;
  localparam logic [1:0] PH_END    = 2'd3;

  logic [1:0]                      phase_r, phase_nxt;
  logic [pfc_pkg::RUN_W-1:0]       run_r, run_nxt;
  logic [pfc_pkg::CONT_W-1:0]      cont_r, cont_nxt;
  logic [pfc_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic                            failed_r, failed_nxt;

  logic                            accept;
  logic                            is_zero;
  logic                            is_digit;
  logic [pfc_pkg::ACC_W-1:0]       acc_shift;
  logic [pfc_pkg::CONT_W-1:0]      cont_dec;
  logic [pfc_pkg::RUN_W-1:0]       run_inc;
  logic                            res_valid;
  pfc_pkg::result_t                res;

  logic                            out_valid_r;
  pfc_pkg::result_t                out_r;
  logic                            skid_valid_r;
  pfc_pkg::result_t                skid_r;
  logic                            out_load;

  assign accept    = in_valid && !in_stall;
  assign is_zero   = (in_ch == 8'h00);
  assign is_digit  = (in_ch inside {[8'h30:8'h39]});
  assign acc_shift = {acc_r[pfc_pkg::ACC_W-7:0], in_ch[5:0]};
  assign cont_dec  = cont_r - 2'd1;
  assign run_inc   = run_r + 3'd1;

  assign res_valid = accept && is_zero;
  always_comb begin
    res.plate_ok         = !failed_r && (phase_r == PH_END);
    res.letter_codepoint = res.plate_ok ? acc_r[pfc_pkg::CP_W-1:0] : '0;
  end

  always_comb begin
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    cont_nxt   = cont_r;
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    if (is_zero) begin
      phase_nxt  = PH_PREFIX;
      run_nxt    = '0;
      cont_nxt   = '0;
      acc_nxt    = '0;
      failed_nxt = 1'b0;
    end else if (!failed_r) begin
      case (phase_r)
        PH_PREFIX: begin
          if (is_digit && run_r < pfc_pkg::PREFIX_MAX) begin
            run_nxt = run_inc;
          end else if (run_r >= pfc_pkg::PREFIX_MIN) begin
            if ((in_ch & 8'hE0) == 8'hC0) begin
              acc_nxt   = {13'd0, in_ch & 8'h1F};
              cont_nxt  = 2'd1;
              phase_nxt = PH_CONT;
            end else if ((in_ch & 8'hF0) == 8'hE0) begin
              acc_nxt   = {13'd0, in_ch & 8'h0F};
              cont_nxt  = 2'd2;
              phase_nxt = PH_CONT;
            end else if ((in_ch & 8'hF8) == 8'hF0) begin
              acc_nxt   = {13'd0, in_ch & 8'h07};
              cont_nxt  = 2'd3;
              phase_nxt = PH_CONT;
            end else begin
              failed_nxt = 1'b1;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_CONT: begin
          if ((in_ch & 8'hC0) != 8'h80) begin
            failed_nxt = 1'b1;
          end else begin
            acc_nxt  = acc_shift;
            cont_nxt = cont_dec;
            if (cont_dec == 2'd0) begin
              if (acc_shift >= pfc_pkg::SYL_LOW && acc_shift <= pfc_pkg::SYL_HIGH) begin
                phase_nxt = PH_SUFFIX;
                run_nxt   = '0;
              end else begin
                failed_nxt = 1'b1;
              end
            end
          end
        end
        PH_SUFFIX: begin
          if (is_digit) begin
            run_nxt = run_inc;
            if (run_inc == pfc_pkg::SUFFIX_LEN) begin
              phase_nxt = PH_END;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      run_r    <= '0;
      cont_r   <= '0;
      acc_r    <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      cont_r   <= cont_nxt;
      acc_r    <= acc_nxt;
      failed_r <= failed_nxt;
    end
  end

  // output register with skid buffer behind it
  assign out_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_load && res_valid) begin
      skid_r <= res;
    end
  end

  assign in_stall             = skid_valid_r;
  assign out_valid            = out_valid_r;
  assign out_plate_ok         = out_r.plate_ok;
  assign out_letter_codepoint = out_r.letter_codepoint;

endmodule

// ----- hw/rtl/pfc_checker.sv -----
// port-level assertions for the plate format checker, bound to the top level
// depends on pfc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [pfc_pkg::CH_W-1:0] in_ch,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_plate_ok,
  input logic [pfc_pkg::CP_W-1:0] out_letter_codepoint
);

  // a held result keeps its word
  `PFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_plate_ok) && $stable(out_letter_codepoint))

  // input only stalls while a result is waiting
  `PFC_ASSERT_IMPL(a_stall_needs_out, in_stall, out_valid)

  // a terminator taken with room at the output shows up next cycle
  `PFC_ASSERT_NEXT(a_zero_gives_result, in_valid && !in_stall && in_ch == 8'h00 && (!out_valid || !out_stall), out_valid)

  // a nonzero word with an empty output creates no result
  `PFC_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && in_ch != 8'h00 && !out_valid, !out_valid)

  // a failed plate carries no code point
  `PFC_ASSERT_IMPL(a_fail_zero_cp, out_valid && !out_plate_ok, out_letter_codepoint == '0)

endmodule

bind plate_format_checker pfc_checker u_pfc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_ch                (in_ch),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_plate_ok         (out_plate_ok),
  .out_letter_codepoint (out_letter_codepoint)
);

// ----- tb/pfc_scoreboard.sv -----
// plate verdict predictor and output comparator for the plate format checker
// depends on pfc_pkg; instantiated beside the block by tb_plate_format_checker
`timescale 1ns / 1ps

module pfc_scoreboard (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [pfc_pkg::CH_W-1:0] in_ch,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_plate_ok,
  input  logic [pfc_pkg::CP_W-1:0] out_letter_codepoint,
  output int                       pending,
  output int                       mismatches
);

  localparam logic [pfc_pkg::CH_W-1:0] CH_NUL     = 8'h00;
  localparam logic [pfc_pkg::CH_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [pfc_pkg::CH_W-1:0] CH_DIGIT_9 = 8'h39;

  typedef enum logic [2:0] {
    SCAN_PREFIX,
    SCAN_CONT,
    SCAN_SUFFIX,
    SCAN_END
  } scan_phase_t;

  scan_phase_t                  scan_phase;
  logic [pfc_pkg::RUN_W-1:0]    run_cnt;
  logic [pfc_pkg::CONT_W-1:0]   cont_left;
  logic [pfc_pkg::ACC_W-1:0]    code_acc;
  logic                         failed;
  pfc_pkg::result_t             plate_verdicts[$];
  pfc_pkg::result_t             want;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_scan();
    scan_phase = SCAN_PREFIX;
    run_cnt    = '0;
    cont_left  = '0;
    code_acc   = '0;
    failed     = 1'b0;
  endtask

  task automatic take_lead(input logic [pfc_pkg::CH_W-1:0] c);
    if (c[7:5] == 3'b110) begin
      code_acc  = pfc_pkg::ACC_W'(c[4:0]);
      cont_left = 2'd1;
      scan_phase = SCAN_CONT;
    end else if (c[7:4] == 4'b1110) begin
      code_acc  = pfc_pkg::ACC_W'(c[3:0]);
      cont_left = 2'd2;
      scan_phase = SCAN_CONT;
    end else if (c[7:3] == 5'b11110) begin
      code_acc  = pfc_pkg::ACC_W'(c[2:0]);
      cont_left = 2'd3;
      scan_phase = SCAN_CONT;
    end else begin
      failed = 1'b1;
    end
  endtask

  task automatic scan_plate_byte(input logic [pfc_pkg::CH_W-1:0] c);
    pfc_pkg::result_t res;
    logic             is_digit;
    is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    if (c == CH_NUL) begin
      res.plate_ok         = !failed && (scan_phase == SCAN_END);
      res.letter_codepoint = res.plate_ok ? code_acc[pfc_pkg::CP_W-1:0] : '0;
      plate_verdicts.push_back(res);
      clear_scan();
    end else if (!failed) begin
      case (scan_phase)
        SCAN_PREFIX: begin
          if (is_digit && run_cnt < pfc_pkg::PREFIX_MAX) run_cnt++;
          else if (run_cnt >= pfc_pkg::PREFIX_MIN) take_lead(c);
          else failed = 1'b1;
        end
        SCAN_CONT: begin
          if (c[7:6] != 2'b10) begin
            failed = 1'b1;
          end else begin
            code_acc  = {code_acc[pfc_pkg::ACC_W-7:0], c[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == '0) begin
              if (code_acc >= pfc_pkg::SYL_LOW && code_acc <= pfc_pkg::SYL_HIGH) begin
                scan_phase = SCAN_SUFFIX;
                run_cnt    = '0;
              end else begin
                failed = 1'b1;
              end
            end
          end
        end
        SCAN_SUFFIX: begin
          if (is_digit) begin
            run_cnt++;
            if (run_cnt == pfc_pkg::SUFFIX_LEN) scan_phase = SCAN_END;
          end else begin
            failed = 1'b1;
          end
        end
        default: failed = 1'b1;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      plate_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (plate_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected word: plate_ok=%0b codepoint=%h",
                                    out_plate_ok, out_letter_codepoint));
        end else begin
          want = plate_verdicts.pop_front();
          if (out_plate_ok !== want.plate_ok)
            report_mismatch($sformatf("plate_ok: got %b, want %b",
                                      out_plate_ok, want.plate_ok));
          if (out_letter_codepoint !== want.letter_codepoint)
            report_mismatch($sformatf("letter_codepoint: got %h, want %h",
                                      out_letter_codepoint, want.letter_codepoint));
        end
      end
      if (in_valid && !in_stall) scan_plate_byte(in_ch);
    end
    pending <= plate_verdicts.size();
  end

endmodule

// ----- tb/tb_plate_format_checker.sv -----
// testbench top for plate_format_checker: clock, reset, plate string stimulus, verdict
// depends on pfc_pkg, plate_format_checker and pfc_scoreboard
`timescale 1ns / 1ps

module tb_plate_format_checker;

  localparam logic [pfc_pkg::CH_W-1:0] CH_NUL     = 8'h00;
  localparam logic [pfc_pkg::CH_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [pfc_pkg::CH_W-1:0] CH_DIGIT_9 = 8'h39;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [pfc_pkg::CH_W-1:0] in_ch = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_plate_ok;
  logic [pfc_pkg::CP_W-1:0] out_letter_codepoint;

  int                       pending_cnt;
  int                       mismatch_cnt;
  int                       words_sent = 0;
  int                       tx_idle_pct = 0;
  int                       rx_idle_pct = 0;
  int                       hold_reqs = 0;
  int                       hold_served = 0;
  int                       hold_left = 0;
  logic [pfc_pkg::CH_W-1:0] str_q[$];

  always #1 clk = ~clk;

  plate_format_checker i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ch                (in_ch),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_plate_ok         (out_plate_ok),
    .out_letter_codepoint (out_letter_codepoint)
  );

  pfc_scoreboard i_scoreboard (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ch                (in_ch),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_plate_ok         (out_plate_ok),
    .out_letter_codepoint (out_letter_codepoint),
    .pending              (pending_cnt),
    .mismatches           (mismatch_cnt)
  );

  // result side: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_reqs;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic logic [pfc_pkg::CH_W-1:0] rand_digit();
    return pfc_pkg::CH_W'(CH_DIGIT_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [pfc_pkg::CH_W-1:0] non_digit();
    logic [pfc_pkg::CH_W-1:0] b;
    do b = pfc_pkg::CH_W'($urandom_range(1, 255));
    while (b >= CH_DIGIT_0 && b <= CH_DIGIT_9);
    return b;
  endfunction

  function automatic logic [pfc_pkg::CH_W-1:0] bad_lead();
    logic [pfc_pkg::CH_W-1:0] b;
    case ($urandom_range(0, 2))
      0: begin
        do b = pfc_pkg::CH_W'($urandom_range(1, 127));
        while (b >= CH_DIGIT_0 && b <= CH_DIGIT_9);
      end
      1: b = pfc_pkg::CH_W'($urandom_range(8'h80, 8'hBF));
      default: b = pfc_pkg::CH_W'($urandom_range(8'hF8, 8'hFF));
    endcase
    return b;
  endfunction

  function automatic logic [pfc_pkg::CH_W-1:0] bad_cont();
    logic [pfc_pkg::CH_W-1:0] b;
    do b = pfc_pkg::CH_W'($urandom_range(1, 255));
    while (b[7:6] == 2'b10);
    return b;
  endfunction

  function automatic logic [pfc_pkg::ACC_W-1:0] near_bound_cp();
    logic [pfc_pkg::ACC_W-1:0] cp;
    case ($urandom_range(0, 3))
      0: cp = pfc_pkg::ACC_W'(pfc_pkg::SYL_LOW - 1);
      1: cp = pfc_pkg::SYL_LOW;
      2: cp = pfc_pkg::SYL_HIGH;
      default: cp = pfc_pkg::ACC_W'(pfc_pkg::SYL_HIGH + 1);
    endcase
    return cp;
  endfunction

  function automatic void push_char(input logic [pfc_pkg::ACC_W-1:0] cp, input int nbytes);
    case (nbytes)
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // mostly well-formed plates, the rest with one defect or plain noise
  task automatic build_string();
    int kind;
    int npre;
    int nsuf;
    int pos;
    int n;
    str_q.delete();
    kind = $urandom_range(0, 23);
    npre = $urandom_range(2, 3);
    nsuf = 4;
    if (kind == 1) npre = $urandom_range(0, 5);
    if (kind == 2) nsuf = $urandom_range(0, 6);
    if (kind == 12) begin
      n = $urandom_range(0, 12);
      repeat (n) str_q.push_back(pfc_pkg::CH_W'($urandom_range(1, 255)));
    end else begin
      repeat (npre) str_q.push_back(rand_digit());
      case (kind)
        3: str_q.push_back(bad_lead());
        4: push_char(pfc_pkg::ACC_W'($urandom_range(0, 2047)), 2);
        5: push_char(pfc_pkg::ACC_W'($urandom_range(0, 65535)), 3);
        6: push_char(pfc_pkg::ACC_W'($urandom_range(0, 2097151)), 4);
        7: push_char(pfc_pkg::ACC_W'($urandom_range(pfc_pkg::SYL_LOW, pfc_pkg::SYL_HIGH)), 4);
        13: push_char(near_bound_cp(), 3);
        default: push_char(pfc_pkg::ACC_W'($urandom_range(pfc_pkg::SYL_LOW,
                                                             pfc_pkg::SYL_HIGH)), 3);
      endcase
      if (kind == 8) begin
        pos = str_q.size() - 1 - $urandom_range(0, 1);
        str_q[pos] = bad_cont();
      end
      repeat (nsuf) str_q.push_back(rand_digit());
      if (kind == 9) begin
        n = $urandom_range(1, 3);
        repeat (n) str_q.push_back(pfc_pkg::CH_W'($urandom_range(1, 255)));
      end
      if (kind == 10) begin
        pos = $urandom_range(0, str_q.size() - 1);
        str_q[pos] = non_digit();
      end
      if (kind == 11) begin
        n = $urandom_range(0, str_q.size() - 1);
        while (str_q.size() > n) void'(str_q.pop_back());
      end
    end
    str_q.push_back(CH_NUL);
  endtask

  task automatic send_word(input logic [pfc_pkg::CH_W-1:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_word(str_q[i]);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty string
    str_q.delete();
    str_q.push_back(CH_NUL);
    send_string();
    // three-digit prefix, highest syllable
    str_q.delete();
    str_q.push_back(8'h39);
    str_q.push_back(8'h38);
    str_q.push_back(8'h30);
    push_char(pfc_pkg::SYL_HIGH, 3);
    str_q.push_back(8'h30);
    str_q.push_back(8'h31);
    str_q.push_back(8'h32);
    str_q.push_back(8'h39);
    str_q.push_back(CH_NUL);
    send_string();
    // two-digit prefix, overlong four-byte lowest syllable
    str_q.delete();
    str_q.push_back(8'h30);
    str_q.push_back(8'h39);
    push_char(pfc_pkg::SYL_LOW, 4);
    repeat (4) str_q.push_back(8'h39);
    str_q.push_back(CH_NUL);
    send_string();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct <= 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct <= 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          // long result hold while strings keep coming
          hold_reqs <= hold_reqs + 1;
          repeat (8) begin
            str_q.delete();
            str_q.push_back(CH_NUL);
            send_string();
          end
        end
      endcase
      while (words_sent < (ph + 1) * 590) begin
        build_string();
        send_string();
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pfc_pkg.sv
hw/rtl/plate_format_checker.sv
hw/rtl/pfc_checker.sv
tb/pfc_scoreboard.sv
tb/tb_plate_format_checker.sv
